// File: rtl/hmc_pkg.sv
// Shared types, constants and the NTC table of the humidity and thermistor converter.
`timescale 1ns / 1ps
package hmc_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 80;
   localparam int TABLE_CAP     = 128;
   localparam int TABLE_IDX_W   = $clog2(TABLE_CAP);
   localparam int SRCH_CNT_W    = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_W       = 12;

   // field widths
   localparam int ADC_W  = 10;
   localparam int K_W    = 7;
   localparam int MV_W   = 13;
   localparam int READ_W = 8;

   // serial multiplier and divider geometry
   localparam int MCAND_W    = 13;
   localparam int MPLIER_W   = 14;
   localparam int PROD_W     = MCAND_W + MPLIER_W;
   localparam int MUL_STEPS  = MPLIER_W;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);
   localparam int DVD_W      = 26;
   localparam int DVSR_W     = 13;
   localparam int DIV_STEPS  = DVD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   // scaling constants
   localparam logic [MPLIER_W-1:0] MV_SCALE      = 14'd5000;
   localparam logic [DVSR_W-1:0]   ADC_FULL      = 13'd1023;
   localparam logic [MV_W-1:0]     FULL_MV       = 13'd5000;
   localparam logic [MV_W-1:0]     HUM_OFFSET_MV = 13'd660;
   localparam logic [MPLIER_W-1:0] HUM_SLOPE_NUM = 14'd75;
   localparam logic [DVSR_W-1:0]   HUM_SLOPE_DEN = 13'd2475;
   localparam logic [READ_W-1:0]   HUM_BASE      = 8'd20;
   localparam logic [MPLIER_W-1:0] K_SCALE       = 14'd100;
   localparam logic [ENTRY_W-1:0]  R_SAT         = 12'd4095;
   localparam logic [K_W-1:0]      K_RESET       = 7'd10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MV_MUL,
      ST_MV_DIV,
      ST_HUM_MUL,
      ST_HUM_DIV,
      ST_K_MUL,
      ST_R_MUL,
      ST_R_DIV,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // NTC resistance per degree C in 10-ohm units; entries past the data read 0
   function automatic logic [ENTRY_W-1:0] ntc_entry(input logic [TABLE_IDX_W-1:0] idx);
      logic [ENTRY_W-1:0] val;
      case (idx)
         7'd0:  val = 12'd3274;  7'd1:  val = 12'd3111;  7'd2:  val = 12'd2957;
         7'd3:  val = 12'd2812;  7'd4:  val = 12'd2674;  7'd5:  val = 12'd2545;
         7'd6:  val = 12'd2422;  7'd7:  val = 12'd2306;  7'd8:  val = 12'd2196;
         7'd9:  val = 12'd2092;  7'd10: val = 12'd1994;  7'd11: val = 12'd1900;
         7'd12: val = 12'd1812;  7'd13: val = 12'd1728;  7'd14: val = 12'd1648;
         7'd15: val = 12'd1573;  7'd16: val = 12'd1502;  7'd17: val = 12'd1434;
         7'd18: val = 12'd1369;  7'd19: val = 12'd1308;  7'd20: val = 12'd1250;
         7'd21: val = 12'd1195;  7'd22: val = 12'd1142;  7'd23: val = 12'd1092;
         7'd24: val = 12'd1045;  7'd25: val = 12'd1000;  7'd26: val = 12'd957;
         7'd27: val = 12'd916;   7'd28: val = 12'd877;   7'd29: val = 12'd840;
         7'd30: val = 12'd805;   7'd31: val = 12'd771;   7'd32: val = 12'd739;
         7'd33: val = 12'd709;   7'd34: val = 12'd680;   7'd35: val = 12'd652;
         7'd36: val = 12'd626;   7'd37: val = 12'd600;   7'd38: val = 12'd576;
         7'd39: val = 12'd553;   7'd40: val = 12'd531;   7'd41: val = 12'd510;
         7'd42: val = 12'd490;   7'd43: val = 12'd471;   7'd44: val = 12'd453;
         7'd45: val = 12'd435;   7'd46: val = 12'd419;   7'd47: val = 12'd403;
         7'd48: val = 12'd387;   7'd49: val = 12'd373;   7'd50: val = 12'd359;
         7'd51: val = 12'd345;   7'd52: val = 12'd332;   7'd53: val = 12'd320;
         7'd54: val = 12'd308;   7'd55: val = 12'd297;   7'd56: val = 12'd286;
         7'd57: val = 12'd276;   7'd58: val = 12'd266;   7'd59: val = 12'd257;
         7'd60: val = 12'd247;   7'd61: val = 12'd239;   7'd62: val = 12'd230;
         7'd63: val = 12'd222;   7'd64: val = 12'd215;   7'd65: val = 12'd207;
         7'd66: val = 12'd200;   7'd67: val = 12'd193;   7'd68: val = 12'd186;
         7'd69: val = 12'd180;   7'd70: val = 12'd174;   7'd71: val = 12'd168;
         7'd72: val = 12'd162;   7'd73: val = 12'd157;   7'd74: val = 12'd152;
         7'd75: val = 12'd147;   7'd76: val = 12'd142;   7'd77: val = 12'd137;
         7'd78: val = 12'd133;   7'd79: val = 12'd129;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/hmc_mul.sv
// Shift-add multiplier that takes one multiplier bit per cycle.
`timescale 1ns / 1ps
module hmc_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hmc_pkg::MCAND_W-1:0]    mcand,
   input  logic [hmc_pkg::MPLIER_W-1:0]   mplier,
   output logic [hmc_pkg::PROD_W-1:0]     product,
   output hmc_pkg::unit_stat_type         stat
);
   import hmc_pkg::*;

   logic [PROD_W-1:0]    acc_ff;
   logic [PROD_W-1:0]    mc_ff;
   logic [MPLIER_W-1:0]  mp_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= MUL_CNT_W'(MUL_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == MUL_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         mc_ff  <= PROD_W'(mcand);
         mp_ff  <= mplier;
      end else if (busy_ff) begin
         // add the shifted multiplicand for each set multiplier bit
         if (mp_ff[0])
            acc_ff <= acc_ff + mc_ff;
         mc_ff <= {mc_ff[PROD_W-2:0], 1'b0};
         mp_ff <= {1'b0, mp_ff[MPLIER_W-1:1]};
      end
   end

   assign product   = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/hmc_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module hmc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hmc_pkg::DVD_W-1:0]   dividend,
   input  logic [hmc_pkg::DVSR_W-1:0]  divisor,
   output logic [hmc_pkg::DVD_W-1:0]   quotient,
   output hmc_pkg::unit_stat_type      stat
);
   import hmc_pkg::*;

   logic [DVD_W-1:0]     dvd_ff;
   logic [DVSR_W-1:0]    rem_ff;
   logic [DVSR_W-1:0]    dvsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DVSR_W+1:0]    trial;
   logic                 qbit;

   // shift in the next dividend bit and try a subtract
   assign trial = {1'b0, rem_ff, dvd_ff[DVD_W-1]} - {2'b00, dvsr_ff};
   assign qbit  = ~trial[DVSR_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff  <= dividend;
         rem_ff  <= '0;
         dvsr_ff <= divisor;
      end else if (busy_ff) begin
         if (qbit)
            rem_ff <= trial[DVSR_W-1:0];
         else
            rem_ff <= {rem_ff[DVSR_W-2:0], dvd_ff[DVD_W-1]};
         // quotient bits fill the dividend register from the bottom
         dvd_ff <= {dvd_ff[DVD_W-2:0], qbit};
      end
   end

   assign quotient  = dvd_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/hmc_ntc_search.sv
// Sequential NTC table walk, one entry per cycle.
`timescale 1ns / 1ps
module hmc_ntc_search (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [hmc_pkg::ENTRY_W-1:0]     resist,
   output logic [hmc_pkg::SRCH_CNT_W-1:0]  index,
   output logic                            beyond,
   output hmc_pkg::unit_stat_type          stat
);
   import hmc_pkg::*;

   logic [SRCH_CNT_W-1:0] idx_ff;
   logic [ENTRY_W-1:0]    r_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic                  at_end;
   logic                  stop;

   assign at_end = (idx_ff == SRCH_CNT_W'(TABLE_ENTRIES));
   assign stop   = at_end || !(r_ff < ntc_entry(TABLE_IDX_W'(idx_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && stop) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         idx_ff <= '0;
         r_ff   <= resist;
      end else if (busy_ff && !stop) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   assign index     = idx_ff;
   assign beyond    = at_end;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/humidity_thermistor_converter_core.sv
// Top level: sequencer, shared serial units, pull-down register and result register.
//
// Use: send one sample on the req_ channel (tdata = 10-bit ADC reading, tuser = kind,
// 0 humidity, 1 temperature). One result comes back on the rsp_ channel (tdata =
// reading, tuser = beyond_table). The pull-down value in kilo-ohms is written on
// csr_wr_en / csr_wr_data; the user must write it only while the block is idle, which
// the block itself does not enforce; it resets to 10. A bit-serial multiplier and a
// bit-serial restoring divider are shared by all the arithmetic steps.
// Humidity: two products and two quotients.
// Temperature: three products and two quotients, then a table walk of one entry per
// cycle; a full-scale sample skips the resistance math and goes straight to the walk.
// One sample is processed at a time; req_tready is high only between samples, so a
// new transfer can come in the cycle after the result loads.
// The finished result sits in an output register, so a new sample is taken while it
// waits. If the receiver stalls and a second result is ready, the block holds that
// result and accepts nothing until the first is taken.
// Reset (synchronous, active high) empties the result register and returns to idle.
`timescale 1ns / 1ps
module humidity_thermistor_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,   // pull_down_kohm
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [9:0] adc_sample, [15:10] zero
   input  logic        req_tuser,     // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // [7:0] reading
   output logic        rsp_tuser      // beyond_table
);
   import hmc_pkg::*;

   state_type state_ff, state_in;

   logic [K_W-1:0]    pull_down_ff;
   logic              kind_ff;
   logic [MV_W-1:0]   mv_ff;
   logic              neg_ff;
   logic [READ_W-1:0] pend_reading_ff;
   logic              pend_flag_ff;
   logic              rsp_valid_ff;
   logic [READ_W-1:0] rsp_reading_ff;
   logic              rsp_flag_ff;

   logic                  mul_start;
   logic [MCAND_W-1:0]    mul_mcand;
   logic [MPLIER_W-1:0]   mul_mplier;
   logic [PROD_W-1:0]     mul_product;
   unit_stat_type         mul_stat;
   logic                  div_start;
   logic [DVD_W-1:0]      div_dividend;
   logic [DVSR_W-1:0]     div_divisor;
   logic [DVD_W-1:0]      div_quot;
   unit_stat_type         div_stat;
   logic                  srch_start;
   logic [ENTRY_W-1:0]    srch_resist;
   logic [SRCH_CNT_W-1:0] srch_index;
   logic                  srch_beyond;
   unit_stat_type         srch_stat;

   logic              req_xfer;
   logic              rsp_load;
   logic [MV_W-1:0]   mv_now;
   logic              mv_below;
   logic [MV_W-1:0]   mv_mag;
   logic [ENTRY_W-1:0] r_sat;
   logic [READ_W-1:0] hum_reading;

   hmc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .product (mul_product),
      .stat    (mul_stat)
   );

   hmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   hmc_ntc_search u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (srch_start),
      .resist (srch_resist),
      .index  (srch_index),
      .beyond (srch_beyond),
      .stat   (srch_stat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // millivolts straight off the divider, and the humidity offset magnitude
   assign mv_now   = div_quot[MV_W-1:0];
   assign mv_below = mv_now < HUM_OFFSET_MV;
   assign mv_mag   = mv_below ? (HUM_OFFSET_MV - mv_now) : (mv_now - HUM_OFFSET_MV);

   // saturate the divider resistance at the table range
   assign r_sat = (|div_quot[DVD_W-1:ENTRY_W]) ? R_SAT : div_quot[ENTRY_W-1:0];

   assign hum_reading = neg_ff ? (HUM_BASE - div_quot[READ_W-1:0])
                               : (HUM_BASE + div_quot[READ_W-1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_xfer) state_in = ST_MV_MUL;
         ST_MV_MUL:  if (mul_stat.done) state_in = ST_MV_DIV;
         ST_MV_DIV: begin
            if (div_stat.done) begin
               if (!kind_ff)
                  state_in = ST_HUM_MUL;
               else if (mv_now == FULL_MV)
                  state_in = ST_SEARCH;
               else
                  state_in = ST_K_MUL;
            end
         end
         ST_HUM_MUL: if (mul_stat.done) state_in = ST_HUM_DIV;
         ST_HUM_DIV: if (div_stat.done) state_in = ST_FINISH;
         ST_K_MUL:   if (mul_stat.done) state_in = ST_R_MUL;
         ST_R_MUL:   if (mul_stat.done) state_in = ST_R_DIV;
         ST_R_DIV:   if (div_stat.done) state_in = ST_SEARCH;
         ST_SEARCH:  if (srch_stat.done) state_in = ST_FINISH;
         ST_FINISH:  if (rsp_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // unit launches and operands
   always_comb begin
      mul_start    = 1'b0;
      mul_mcand    = '0;
      mul_mplier   = '0;
      div_start    = 1'b0;
      div_dividend = DVD_W'(mul_product);
      div_divisor  = ADC_FULL;
      srch_start   = 1'b0;
      srch_resist  = r_sat;
      case (state_ff)
         ST_IDLE: begin
            mul_start  = req_xfer;
            mul_mcand  = MCAND_W'(req_tdata[ADC_W-1:0]);
            mul_mplier = MV_SCALE;
         end
         ST_MV_MUL: begin
            div_start   = mul_stat.done;
            div_divisor = ADC_FULL;
         end
         ST_MV_DIV: begin
            if (div_stat.done) begin
               if (!kind_ff) begin
                  mul_start  = 1'b1;
                  mul_mcand  = mv_mag;
                  mul_mplier = HUM_SLOPE_NUM;
               end else if (mv_now == FULL_MV) begin
                  srch_start  = 1'b1;
                  srch_resist = R_SAT;
               end else begin
                  mul_start  = 1'b1;
                  mul_mcand  = MCAND_W'(pull_down_ff);
                  mul_mplier = K_SCALE;
               end
            end
         end
         ST_HUM_MUL: begin
            div_start   = mul_stat.done;
            div_divisor = HUM_SLOPE_DEN;
         end
         ST_K_MUL: begin
            mul_start  = mul_stat.done;
            mul_mcand  = mv_ff;
            mul_mplier = mul_product[MPLIER_W-1:0];
         end
         ST_R_MUL: begin
            div_start   = mul_stat.done;
            div_divisor = FULL_MV - mv_ff;
         end
         ST_R_DIV: begin
            srch_start = div_stat.done;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pull_down_ff <= K_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en)
            pull_down_ff <= csr_wr_data;
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer)
         kind_ff <= req_tuser;
      if (state_ff == ST_MV_DIV && div_stat.done) begin
         mv_ff  <= mv_now;
         neg_ff <= mv_below;
      end
      if (state_ff == ST_HUM_DIV && div_stat.done) begin
         pend_reading_ff <= hum_reading;
         pend_flag_ff    <= 1'b0;
      end
      if (state_ff == ST_SEARCH && srch_stat.done) begin
         pend_reading_ff <= READ_W'(srch_index);
         pend_flag_ff    <= srch_beyond;
      end
      if (rsp_load) begin
         rsp_reading_ff <= pend_reading_ff;
         rsp_flag_ff    <= pend_flag_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_reading_ff;
   assign rsp_tuser  = rsp_flag_ff;

   // the serial units never overlap
   assert property (@(posedge clock) disable iff (reset)
      $countones({mul_stat.busy, div_stat.busy, srch_stat.busy}) <= 1)
      else $error("serial units busy at the same time");

   // an accepted sample starts the multiplier
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> mul_stat.busy)
      else $error("accepted sample did not start the multiplier");

   // a table overrun reports the table length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flag_ff |-> rsp_reading_ff == READ_W'(TABLE_ENTRIES))
      else $error("beyond_table set with a wrong reading");

   // humidity stays in range
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HUM_DIV && div_stat.done |-> hum_reading <= 8'd151)
      else $error("humidity reading out of range");

endmodule

// File: sim/humidity_thermistor_converter_core_tb.sv
// Self-checking testbench for the humidity and thermistor converter core.
`timescale 1ns / 1ps
module humidity_thermistor_converter_core_tb;
   import hmc_pkg::*;

   localparam int CLK_HALF         = 10;
   localparam int RESET_CYCLES     = 7;
   localparam int CYCLE_LIMIT      = 1_500_000;
   localparam int DRAIN_CYCLES     = 200;
   localparam int BLOCK_SAMPLES    = 75;
   localparam int BLOCKS_PER_PHASE = 5;
   localparam int CURVE_POINTS     = 80;

   localparam int FULL_SCALE_MV = 5000;
   localparam int ADC_SPAN      = 1023;
   localparam int HUM_ZERO_MV   = 660;
   localparam int HUM_GAIN      = 75;
   localparam int HUM_DIV       = 2475;
   localparam int HUM_FLOOR     = 20;
   localparam int KOHM_TO_OHM10 = 100;
   localparam int R_CEIL        = 4095;

   typedef enum logic {
      KIND_HUMIDITY    = 1'b0,
      KIND_TEMPERATURE = 1'b1
   } sample_kind_type;

   typedef struct packed {
      logic [7:0] reading;
      logic       beyond_table;
   } reading_type;

   // thermistor resistance per degree C, 10-ohm units, index 0 first
   localparam logic [0:CURVE_POINTS-1][11:0] NTC_CURVE = {
      12'd3274, 12'd3111, 12'd2957, 12'd2812, 12'd2674, 12'd2545, 12'd2422, 12'd2306,
      12'd2196, 12'd2092, 12'd1994, 12'd1900, 12'd1812, 12'd1728, 12'd1648, 12'd1573,
      12'd1502, 12'd1434, 12'd1369, 12'd1308, 12'd1250, 12'd1195, 12'd1142, 12'd1092,
      12'd1045, 12'd1000, 12'd957,  12'd916,  12'd877,  12'd840,  12'd805,  12'd771,
      12'd739,  12'd709,  12'd680,  12'd652,  12'd626,  12'd600,  12'd576,  12'd553,
      12'd531,  12'd510,  12'd490,  12'd471,  12'd453,  12'd435,  12'd419,  12'd403,
      12'd387,  12'd373,  12'd359,  12'd345,  12'd332,  12'd320,  12'd308,  12'd297,
      12'd286,  12'd276,  12'd266,  12'd257,  12'd247,  12'd239,  12'd230,  12'd222,
      12'd215,  12'd207,  12'd200,  12'd193,  12'd186,  12'd180,  12'd174,  12'd168,
      12'd162,  12'd157,  12'd152,  12'd147,  12'd142,  12'd137,  12'd133,  12'd129
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;     // [9:0] adc_sample, [15:10] zero
   logic        req_tuser;     // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;     // [7:0] reading
   logic        rsp_tuser;     // beyond_table

   logic [6:0]  pull_down_kohm;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          samples_sent;
   int          results_checked;
   int          kohm_writes;
   int          error_count;
   int          cycle_count;
   reading_type expected_readings[$];

   humidity_thermistor_converter_core uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #CLK_HALF clock = ~clock;

   // Millivolts, then either the humidity line or divider resistance plus table walk.
   function automatic reading_type convert_sample(input sample_kind_type kind,
                                                  input logic [9:0] adc,
                                                  input logic [6:0] kohm);
      logic [12:0] mv;
      logic [11:0] ohms10;
      int          hum;
      int          quot;
      int          idx;
      reading_type res;
      mv = 13'(int'(adc) * FULL_SCALE_MV / ADC_SPAN);
      res.beyond_table = 1'b0;
      if (kind == KIND_HUMIDITY) begin
         // signed division truncates toward zero, just below 660 mV still reads 20
         hum = (int'(mv) - HUM_ZERO_MV) * HUM_GAIN / HUM_DIV + HUM_FLOOR;
         if (hum < 0) begin
            hum = 0;
         end
         res.reading = 8'(hum);
      end else begin
         if (int'(mv) >= FULL_SCALE_MV) begin
            quot = R_CEIL;
         end else begin
            quot = int'(mv) * int'(kohm) * KOHM_TO_OHM10 / (FULL_SCALE_MV - int'(mv));
         end
         if (quot > R_CEIL) begin
            quot = R_CEIL;
         end
         ohms10 = 12'(quot);
         idx = 0;
         while (idx < TABLE_ENTRIES &&
                ohms10 < (idx < CURVE_POINTS ? NTC_CURVE[idx] : 12'd0)) begin
            idx++;
         end
         res.reading = 8'(idx);
         res.beyond_table = (idx >= TABLE_ENTRIES);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Hold valid across back-to-back transfers; drop it only while idling.
   task automatic send_sample(input sample_kind_type kind, input logic [9:0] adc);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, adc};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      expected_readings.push_back(convert_sample(kind, adc, pull_down_kohm));
      samples_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_pull_down(input logic [6:0] kohm);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= kohm;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pull_down_kohm = kohm;
      kohm_writes++;
   endtask

   task automatic test_humidity_extremes();
      send_sample(KIND_HUMIDITY, 10'd0);
      send_sample(KIND_HUMIDITY, 10'd1023);
      send_sample(KIND_HUMIDITY, 10'd135);
      send_sample(KIND_HUMIDITY, 10'd136);
      send_sample(KIND_HUMIDITY, 10'd512);
   endtask

   // Runs at the reset pull-down, so it also checks the register's reset value.
   task automatic test_temperature_search();
      send_sample(KIND_TEMPERATURE, 10'd0);
      send_sample(KIND_TEMPERATURE, 10'd1);
      send_sample(KIND_TEMPERATURE, 10'd1022);
      send_sample(KIND_TEMPERATURE, 10'd1023);
      send_sample(KIND_TEMPERATURE, 10'd500);
      send_sample(KIND_TEMPERATURE, 10'd700);
      send_sample(KIND_TEMPERATURE, 10'd800);
      send_sample(KIND_TEMPERATURE, 10'd900);
   endtask

   task automatic test_pull_down_extremes();
      set_pull_down(7'd100);
      send_sample(KIND_TEMPERATURE, 10'd1023);
      send_sample(KIND_TEMPERATURE, 10'd100);
      send_sample(KIND_TEMPERATURE, 10'd300);
      set_pull_down(7'd1);
      send_sample(KIND_TEMPERATURE, 10'd1000);
      send_sample(KIND_TEMPERATURE, 10'd900);
      send_sample(KIND_TEMPERATURE, 10'd10);
      // zero pull-down: walk runs off the table, except at full scale
      set_pull_down(7'd0);
      send_sample(KIND_TEMPERATURE, 10'd600);
      send_sample(KIND_TEMPERATURE, 10'd1023);
      set_pull_down(7'd127);
      send_sample(KIND_TEMPERATURE, 10'd512);
      send_sample(KIND_TEMPERATURE, 10'd50);
      set_pull_down(7'd10);
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      logic [9:0]      adc;
      sample_kind_type kind;
      logic [6:0]      kohm;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
         case ($urandom_range(0, 6))
            0: kohm = 7'd1;
            1: kohm = 7'd100;
            2: kohm = 7'd0;
            3: kohm = 7'd127;
            default: kohm = 7'($urandom_range(1, 100));
         endcase
         set_pull_down(kohm);
         for (int n = 0; n < BLOCK_SAMPLES; n++) begin
            kind = sample_kind_type'($urandom_range(0, 1));
            // lean on the rails now and then, where saturation and table ends live
            if ($urandom_range(0, 7) == 0) begin
               adc = $urandom_range(0, 1) ? 10'($urandom_range(1018, 1023))
                                          : 10'($urandom_range(0, 5));
            end else begin
               adc = 10'($urandom_range(0, 1023));
            end
            send_sample(kind, adc);
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("result with nothing outstanding", int'(rsp_tdata), 0);
         end else begin
            want = expected_readings.pop_front();
            results_checked++;
            if (rsp_tdata !== want.reading) begin
               report_mismatch("reading", int'(rsp_tdata), int'(want.reading));
            end
            if (rsp_tuser !== want.beyond_table) begin
               report_mismatch("beyond_table", int'(rsp_tuser), int'(want.beyond_table));
            end
         end
      end
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_readings.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = 1'b0;
      pull_down_kohm  = 7'd10;
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      samples_sent    = 0;
      results_checked = 0;
      kohm_writes     = 0;
      error_count     = 0;
      cycle_count     = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_humidity_extremes();
      test_temperature_search();
      test_pull_down_extremes();
      test_random_traffic(30, 74);
      test_random_traffic(74, 30);
      test_random_traffic(0, 0);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d samples (humidity and temperature), %0d results compared,",
               samples_sent, results_checked);
      $display("across %0d pull-down writes and three sender/receiver stall mixes.",
               kohm_writes);
      if (error_count == 0 && expected_readings.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
